// File: rtl/pcg_pkg.sv
// Shared widths, default parameter values and register indexes for the
// pool reserve cap governor. No dependencies; compiled before all other files.
package pcg_pkg;

  // Field widths of the snapshot, result and configuration beats.
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned SLOT_W  = 16;
  localparam int unsigned SEEN_W  = 13;
  localparam int unsigned CAP_W   = 10;
  localparam int unsigned RES_W   = 13;
  localparam int unsigned TICK_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Default tuning values.
  localparam int unsigned FLOOR_CAP_DEF    = 20;
  localparam int unsigned HYSTERESIS_DEF   = 8;
  localparam int unsigned CUT_TICKS_DEF    = 20;
  localparam int unsigned RAMP_TICKS_DEF   = 15;
  localparam int unsigned MAX_CAPACITY_DEF = 4096;

  // Snapshot check and state constants.
  localparam logic [30:0]       ELEM_SIZE_CODE = 31'h0000_0a50;
  localparam logic [SEEN_W-1:0] MIN_NONE       = '1;
  localparam logic [TICK_W-1:0] TICK_MAX       = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_SETTING = 2'd2;

endpackage

// File: rtl/pcg_in_if.sv
// Snapshot channel: valid/ready handshake plus one pool snapshot per beat.
// Depends on pcg_pkg for field widths.
interface pcg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        pool_present;
  logic [pcg_pkg::ELEM_W-1:0]  element_word;
  logic [pcg_pkg::SLOT_W-1:0]  capacity;
  logic [pcg_pkg::SLOT_W-1:0]  free_slots;

  modport source (output valid, pool_present, element_word, capacity, free_slots,
                  input ready);
  modport sink   (input valid, pool_present, element_word, capacity, free_slots,
                  output ready);
endinterface

// File: rtl/pcg_out_if.sv
// Result channel: valid/ready handshake plus one governor result per beat.
// Depends on pcg_pkg for field widths.
interface pcg_out_if;
  logic                        valid;
  logic                        ready;
  logic                        snapshot_ok;
  logic [pcg_pkg::SEEN_W-1:0]  free_seen;
  logic [pcg_pkg::SEEN_W-1:0]  capacity_seen;
  logic [pcg_pkg::SEEN_W-1:0]  lowest_free;
  logic [pcg_pkg::CAP_W-1:0]   applied_cap;
  logic                        governor_active;
  logic                        fallback_stage;
  logic                        stage_changed;
  logic                        cut_event;

  modport source (output valid, snapshot_ok, free_seen, capacity_seen, lowest_free,
                  applied_cap, governor_active, fallback_stage, stage_changed,
                  cut_event, input ready);
  modport sink   (input valid, snapshot_ok, free_seen, capacity_seen, lowest_free,
                  applied_cap, governor_active, fallback_stage, stage_changed,
                  cut_event, output ready);
endinterface

// File: rtl/pcg_cfg_if.sv
// Configuration write channel: valid/ready handshake, register index and data.
// Depends on pcg_pkg for field widths.
interface pcg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pcg_pkg::CFG_IDX_W-1:0]   index;
  logic [pcg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pool_reserve_cap_governor_unit.sv
// Channel   Dir  Beat contents
// in_bus    in   pool_present, element_word, capacity, free_slots
// out_bus   out  snapshot_ok, free_seen, capacity_seen, lowest_free, applied_cap,
//                governor_active, fallback_stage, stage_changed, cut_event
// cfg_bus   in   index (0 enable, 1 reserve, 2 cap_setting), data
//
// One snapshot per cycle while out_bus.ready stays high: a beat sits in the input
// register, the governor update runs in one pass of compare, subtract and clamp
// logic, and the result lands in the output register.
// The output register holds a result while out_bus.ready is low; the input
// register keeps taking beats as long as the output register can move.
// Active-low sync reset clears all but the data registers; no clearing pass needed.
// Configuration writes are always taken in the cycle they are offered.
// Top level of the pool reserve cap governor.
// Depends on pcg_pkg, pcg_in_if, pcg_out_if and pcg_cfg_if.
module pool_reserve_cap_governor_unit #(
  parameter int unsigned FLOOR_CAP    = pcg_pkg::FLOOR_CAP_DEF,
  parameter int unsigned HYSTERESIS   = pcg_pkg::HYSTERESIS_DEF,
  parameter int unsigned CUT_TICKS    = pcg_pkg::CUT_TICKS_DEF,
  parameter int unsigned RAMP_TICKS   = pcg_pkg::RAMP_TICKS_DEF,
  parameter int unsigned MAX_CAPACITY = pcg_pkg::MAX_CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pcg_in_if.sink     in_bus,
  pcg_out_if.source  out_bus,
  pcg_cfg_if.sink    cfg_bus
);

  localparam int unsigned CW = pcg_pkg::CAP_W;
  localparam int unsigned SW = pcg_pkg::SEEN_W;
  localparam int unsigned TW = pcg_pkg::TICK_W;
  localparam int unsigned AW = pcg_pkg::SLOT_W + 1;

  localparam logic [CW-1:0]               FLOOR_C = CW'(FLOOR_CAP);
  localparam logic [AW-1:0]               HYST_C  = AW'(HYSTERESIS);
  localparam logic [TW-1:0]               CUT_C   = TW'(CUT_TICKS);
  localparam logic [TW-1:0]               RAMP_C  = TW'(RAMP_TICKS);
  localparam logic [pcg_pkg::SLOT_W-1:0]  MAXCAP_C = pcg_pkg::SLOT_W'(MAX_CAPACITY);

  typedef struct packed {
    logic          snapshot_ok;
    logic [SW-1:0] free_seen;
    logic [SW-1:0] capacity_seen;
    logic [SW-1:0] lowest_free;
    logic [CW-1:0] applied_cap;
    logic          governor_active;
    logic          fallback_stage;
    logic          stage_changed;
    logic          cut_event;
  } result_t;

  // Effective cap from the held value, clamped to the wanted cap; zero follows it.
  function automatic logic [CW-1:0] cur_cap(input logic [CW-1:0] held,
                                            input logic [CW-1:0] want);
    logic [CW-1:0] eff;
    eff = (held != '0) ? held : want;
    if (eff > want) begin
      eff = want;
    end
    return eff;
  endfunction

  function automatic logic [TW-1:0] tick_inc(input logic [TW-1:0] t);
    return (t != pcg_pkg::TICK_MAX) ? t + 1'b1 : pcg_pkg::TICK_MAX;
  endfunction

  // Configuration registers.
  logic          enable_r;
  logic [pcg_pkg::RES_W-1:0] reserve_r;
  logic [CW-1:0] cap_setting_r;

  // Input register.
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_present_r;
  logic [pcg_pkg::ELEM_W-1:0] s1_elem_r;
  logic [pcg_pkg::SLOT_W-1:0] s1_cap_r;
  logic [pcg_pkg::SLOT_W-1:0] s1_free_r;

  // Governor state.
  logic [CW-1:0] held_cap_r, held_cap_nxt;
  logic          stage_r, stage_nxt;
  logic [TW-1:0] tsc_r, tsc_nxt;
  logic [TW-1:0] tsr_r, tsr_nxt;
  logic [SW-1:0] min_free_r, min_free_nxt;
  logic [SW-1:0] last_free_r, last_free_nxt;
  logic [SW-1:0] last_cap_r, last_cap_nxt;

  // Output register.
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  logic          in_fire, s1_adv;
  logic          snap_ok, gov_active;
  logic [CW-1:0] wanted, floor_c;

  assign cfg_bus.ready = 1'b1;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      reserve_r     <= '0;
      cap_setting_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        pcg_pkg::REG_ENABLE:      enable_r      <= cfg_bus.data[0];
        pcg_pkg::REG_RESERVE:     reserve_r     <= cfg_bus.data[pcg_pkg::RES_W-1:0];
        pcg_pkg::REG_CAP_SETTING: cap_setting_r <= cfg_bus.data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves whenever the output register can take it.
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready  = !s1_valid_r || s1_adv;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_present_r <= in_bus.pool_present;
      s1_elem_r    <= in_bus.element_word;
      s1_cap_r     <= in_bus.capacity;
      s1_free_r    <= in_bus.free_slots;
    end
  end

  // Snapshot checks and derived caps.
  assign snap_ok = s1_present_r && (s1_elem_r[30:0] == pcg_pkg::ELEM_SIZE_CODE) &&
                   (s1_cap_r != '0) && (s1_cap_r <= MAXCAP_C) && (s1_free_r <= s1_cap_r);
  assign gov_active = enable_r && (reserve_r != '0);
  assign wanted     = (cap_setting_r != '0) ? cap_setting_r : FLOOR_C;
  assign floor_c    = (wanted < FLOOR_C) ? wanted : FLOOR_C;

  // Governor update for the snapshot in the input register.
  always_comb begin
    logic [CW-1:0] eff, gap, cut, room;
    logic [TW-1:0] tc, tr;
    logic [AW-1:0] fr, res, deficit, surplus;
    logic          stg, changed, cut_ev;

    eff     = cur_cap(held_cap_r, wanted);
    gap     = '0;
    cut     = '0;
    room    = '0;
    tc      = tick_inc(tsc_r);
    tr      = tick_inc(tsr_r);
    fr      = {1'b0, s1_free_r};
    res     = AW'(reserve_r);
    deficit = '0;
    surplus = '0;
    stg     = stage_r;
    changed = 1'b0;
    cut_ev  = 1'b0;

    held_cap_nxt  = held_cap_r;
    stage_nxt     = stage_r;
    tsc_nxt       = tsc_r;
    tsr_nxt       = tsr_r;
    min_free_nxt  = min_free_r;
    last_free_nxt = last_free_r;
    last_cap_nxt  = last_cap_r;

    if (s1_adv && snap_ok) begin
      last_free_nxt = s1_free_r[SW-1:0];
      last_cap_nxt  = s1_cap_r[SW-1:0];
      if (s1_free_r < pcg_pkg::SLOT_W'(min_free_r)) begin
        min_free_nxt = s1_free_r[SW-1:0];
      end

      if (!gov_active) begin
        held_cap_nxt = '0;
        stage_nxt    = 1'b0;
        changed      = stage_r;
      end else begin
        if (fr < res) begin
          // Under reserve: cut by the deficit toward the floor.
          if ((tc >= CUT_C) || (fr < (res >> 1))) begin
            deficit = res - fr;
            gap     = (eff > floor_c) ? eff - floor_c : '0;
            cut     = (AW'(gap) < deficit) ? gap : deficit[CW-1:0];
            eff     = eff - cut;
            if ((cut == '0) && (eff <= floor_c)) begin
              stg = 1'b1;
            end
            cut_ev = (cut != '0) || (stg != stage_r);
            tc     = '0;
          end
        end else if ((fr > res + HYST_C) && (tr >= RAMP_C)) begin
          // Well over reserve: drop the stage flag first, then ramp the cap.
          surplus = fr - res - HYST_C;
          if (stg) begin
            stg = 1'b0;
          end else if (eff < wanted) begin
            room = wanted - eff;
            eff  = (surplus >= AW'(room)) ? wanted : eff + surplus[CW-1:0];
          end
          tr = '0;
        end
        held_cap_nxt = (eff == wanted) ? '0 : eff;
        stage_nxt    = stg;
        tsc_nxt      = tc;
        tsr_nxt      = tr;
        changed      = (stg != stage_r);
      end
    end

    res_nxt.snapshot_ok     = snap_ok;
    res_nxt.free_seen       = last_free_nxt;
    res_nxt.capacity_seen   = last_cap_nxt;
    res_nxt.lowest_free     = min_free_nxt;
    res_nxt.applied_cap     = gov_active ? cur_cap(held_cap_nxt, wanted) : FLOOR_C;
    res_nxt.governor_active = gov_active;
    res_nxt.fallback_stage  = stage_nxt;
    res_nxt.stage_changed   = changed;
    res_nxt.cut_event       = cut_ev;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cap_r  <= '0;
      stage_r     <= 1'b0;
      tsc_r       <= '0;
      tsr_r       <= '0;
      min_free_r  <= pcg_pkg::MIN_NONE;
      last_free_r <= '0;
      last_cap_r  <= '0;
    end else begin
      held_cap_r  <= held_cap_nxt;
      stage_r     <= stage_nxt;
      tsc_r       <= tsc_nxt;
      tsr_r       <= tsr_nxt;
      min_free_r  <= min_free_nxt;
      last_free_r <= last_free_nxt;
      last_cap_r  <= last_cap_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.snapshot_ok     = res_r.snapshot_ok;
  assign out_bus.free_seen       = res_r.free_seen;
  assign out_bus.capacity_seen   = res_r.capacity_seen;
  assign out_bus.lowest_free     = res_r.lowest_free;
  assign out_bus.applied_cap     = res_r.applied_cap;
  assign out_bus.governor_active = res_r.governor_active;
  assign out_bus.fallback_stage  = res_r.fallback_stage;
  assign out_bus.stage_changed   = res_r.stage_changed;
  assign out_bus.cut_event       = res_r.cut_event;

  // The lowest free count never rises outside reset.
  a_min_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (min_free_r <= $past(min_free_r)))
    else $error("lowest free count increased");

  // A rejected snapshot reports no stage change and no cut.
  a_bad_snap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.snapshot_ok) |-> (!res_r.stage_changed && !res_r.cut_event))
    else $error("rejected snapshot reported an event");

  // A cut only happens while the governor is active.
  a_cut_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.cut_event) |-> res_r.governor_active)
    else $error("cut reported with governor inactive");

  // A held input beat is neither lost nor overwritten.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_free_r) && $stable(s1_cap_r)))
    else $error("input register changed while held");

endmodule

// File: test/governor_checker.sv
// Checker for the pool reserve cap governor: watches the snapshot, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on pcg_pkg, pcg_in_if, pcg_out_if and pcg_cfg_if.
`timescale 1ns / 1ps

module governor_checker (
  input  logic        clk,
  input  logic        rst_n,
  pcg_in_if           in_bus,
  pcg_out_if          out_bus,
  pcg_cfg_if          cfg_bus,
  output int unsigned mismatch_count,
  output int unsigned results_pending
);
  import pcg_pkg::*;

  localparam int FLOOR  = FLOOR_CAP_DEF;
  localparam int HYST   = HYSTERESIS_DEF;
  localparam int CUT    = CUT_TICKS_DEF;
  localparam int RAMP   = RAMP_TICKS_DEF;
  localparam int MAXCAP = MAX_CAPACITY_DEF;

  typedef struct packed {
    logic              present;
    logic [ELEM_W-1:0] word;
    logic [SLOT_W-1:0] capacity;
    logic [SLOT_W-1:0] free;
  } snapshot_t;

  typedef struct packed {
    logic              ok;
    logic [SEEN_W-1:0] free_seen;
    logic [SEEN_W-1:0] capacity_seen;
    logic [SEEN_W-1:0] lowest_free;
    logic [CAP_W-1:0]  applied_cap;
    logic              active;
    logic              stage;
    logic              stage_changed;
    logic              cut_event;
  } gov_result_t;

  // Register copies.
  logic              gov_enable;
  logic [RES_W-1:0]  reserve_slots;
  logic [CAP_W-1:0]  cap_setting;

  // Governor state.
  logic [CAP_W-1:0]  held_cap;
  logic              stage_flag;
  logic [TICK_W-1:0] ticks_cut;
  logic [TICK_W-1:0] ticks_ramp;
  logic [SEEN_W-1:0] low_free;
  logic [SEEN_W-1:0] last_free;
  logic [SEEN_W-1:0] last_capacity;

  gov_result_t governor_results[$];
  int unsigned mismatches;

  function automatic bit governing();
    return gov_enable && (reserve_slots != 0);
  endfunction

  function automatic int wanted_cap();
    return (cap_setting != 0) ? int'(cap_setting) : FLOOR;
  endfunction

  // A held cap above the current setting is clamped to the setting.
  function automatic int effective_cap();
    int eff;
    eff = (held_cap != 0) ? int'(held_cap) : wanted_cap();
    return (eff > wanted_cap()) ? wanted_cap() : eff;
  endfunction

  function automatic logic [TICK_W-1:0] bump_tick(input logic [TICK_W-1:0] t);
    return (t == TICK_MAX) ? t : t + 1'b1;
  endfunction

  // Advances the governor by one snapshot and returns the result it reports.
  function automatic gov_result_t govern_snapshot(input snapshot_t s);
    gov_result_t r;
    logic        ok;
    logic        was;
    logic        stg;
    int          want;
    int          floor_c;
    int          eff;
    int          fr;
    int          res;
    int          cut;
    int          cap_now;
    r  = '0;
    ok = s.present && (s.word[30:0] == ELEM_SIZE_CODE) && (s.capacity >= 1) &&
         (int'(s.capacity) <= MAXCAP) && (s.free <= s.capacity);
    if (ok) begin
      last_free     = s.free[SEEN_W-1:0];
      last_capacity = s.capacity[SEEN_W-1:0];
      if (s.free < low_free) low_free = s.free[SEEN_W-1:0];
      if (!governing()) begin
        // Governor off: the held cap is dropped and the stage flag cleared.
        held_cap = '0;
        if (stage_flag) begin
          stage_flag      = 1'b0;
          r.stage_changed = 1'b1;
        end
      end else begin
        want    = wanted_cap();
        floor_c = (want < FLOOR) ? want : FLOOR;
        eff     = effective_cap();
        fr      = int'(s.free);
        res     = int'(reserve_slots);
        was     = stage_flag;
        stg     = stage_flag;
        ticks_cut  = bump_tick(ticks_cut);
        ticks_ramp = bump_tick(ticks_ramp);
        if (fr < res) begin
          // Cut by the deficit, at once when far below the reserve.
          if ((int'(ticks_cut) >= CUT) || (fr < res / 2)) begin
            cut = eff - floor_c;
            if (cut > res - fr) cut = res - fr;
            if (cut < 0) cut = 0;
            eff -= cut;
            if ((cut == 0) && (eff <= floor_c)) stg = 1'b1;
            if ((cut != 0) || (stg != was)) r.cut_event = 1'b1;
            ticks_cut = '0;
          end
        end else if ((fr > res + HYST) && (int'(ticks_ramp) >= RAMP)) begin
          // A ramp clears the stage flag first and raises the cap later.
          if (stg) begin
            stg = 1'b0;
          end else if (eff < want) begin
            eff += fr - res - HYST;
            if (eff > want) eff = want;
          end
          ticks_ramp = '0;
        end
        held_cap        = (eff == want) ? '0 : eff[CAP_W-1:0];
        stage_flag      = stg;
        r.stage_changed = (stg != was);
      end
    end
    cap_now         = governing() ? effective_cap() : FLOOR;
    r.ok            = ok;
    r.free_seen     = last_free;
    r.capacity_seen = last_capacity;
    r.lowest_free   = low_free;
    r.applied_cap   = cap_now[CAP_W-1:0];
    r.active        = governing();
    r.stage         = stage_flag;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v)
      report_mismatch($sformatf("%s expected %0d got %0d", name, want_v, got_v));
  endtask

  // Track registers, predict on each snapshot beat, check each result beat.
  always @(posedge clk) begin : watch
    gov_result_t predicted;
    gov_result_t observed;
    if (!rst_n) begin
      gov_enable    = 1'b0;
      reserve_slots = '0;
      cap_setting   = '0;
      held_cap      = '0;
      stage_flag    = 1'b0;
      ticks_cut     = '0;
      ticks_ramp    = '0;
      low_free      = MIN_NONE;
      last_free     = '0;
      last_capacity = '0;
      mismatches    = 0;
      governor_results.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_ENABLE:      gov_enable    = cfg_bus.data[0];
          REG_RESERVE:     reserve_slots = cfg_bus.data[RES_W-1:0];
          REG_CAP_SETTING: cap_setting   = cfg_bus.data[CAP_W-1:0];
          default: ;
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        observed = '{out_bus.snapshot_ok, out_bus.free_seen, out_bus.capacity_seen,
                     out_bus.lowest_free, out_bus.applied_cap, out_bus.governor_active,
                     out_bus.fallback_stage, out_bus.stage_changed, out_bus.cut_event};
        if (governor_results.size() == 0) begin
          report_mismatch("result beat with no snapshot outstanding");
        end else begin
          predicted = governor_results.pop_front();
          compare_field("snapshot_ok", predicted.ok, observed.ok);
          compare_field("free_seen", predicted.free_seen, observed.free_seen);
          compare_field("capacity_seen", predicted.capacity_seen, observed.capacity_seen);
          compare_field("lowest_free", predicted.lowest_free, observed.lowest_free);
          compare_field("applied_cap", predicted.applied_cap, observed.applied_cap);
          compare_field("governor_active", predicted.active, observed.active);
          compare_field("fallback_stage", predicted.stage, observed.stage);
          compare_field("stage_changed", predicted.stage_changed, observed.stage_changed);
          compare_field("cut_event", predicted.cut_event, observed.cut_event);
        end
      end
      if (in_bus.valid && in_bus.ready)
        governor_results.push_back(govern_snapshot('{in_bus.pool_present,
            in_bus.element_word, in_bus.capacity, in_bus.free_slots}));
    end
    results_pending <= governor_results.size();
    mismatch_count  <= mismatches;
  end

endmodule

// File: test/testbench.sv
// Top of the governor testbench: clock, reset, snapshot and register stimulus,
// watchdog and verdict. Depends on pcg_pkg, the channel interfaces, the block
// and governor_checker.
`timescale 1ns / 1ps

module testbench;
  import pcg_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAXCAP      = MAX_CAPACITY_DEF;
  localparam logic [ELEM_W-1:0] WORD_OK = {1'b0, ELEM_SIZE_CODE};

  // Where the free count of a well-formed snapshot sits against the reserve.
  typedef enum int {DEEP_SHORT, SHORT, NEAR, ANY_FREE} free_band_t;
  // Ways a snapshot is broken.
  typedef enum int {DROP_PRESENT, BAD_WORD, BAD_CAPACITY, FREE_OVER} flaw_t;

  logic        clk;
  logic        rst_n;
  logic        steady;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;

  pcg_in_if  snap_if ();
  pcg_out_if res_if ();
  pcg_cfg_if cfg_if ();

  pool_reserve_cap_governor_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (snap_if),
    .out_bus (res_if),
    .cfg_bus (cfg_if)
  );

  governor_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_bus          (snap_if),
    .out_bus         (res_if),
    .cfg_bus         (cfg_if),
    .mismatch_count  (fail_count),
    .results_pending (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // The result side stalls at random outside the steady stretch.
  always @(posedge clk) begin
    res_if.ready <= steady || ($urandom_range(99) >= 24);
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (snap_if.valid && snap_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one snapshot beat after a random gap and waits for it to be taken.
  task automatic offer_snapshot(input logic present, input logic [ELEM_W-1:0] word,
                                input logic [SLOT_W-1:0] cap,
                                input logic [SLOT_W-1:0] free);
    cfg_if.valid <= 1'b0;
    while (!steady && ($urandom_range(99) < 24)) begin
      snap_if.valid <= 1'b0;
      @(posedge clk);
    end
    snap_if.valid        <= 1'b1;
    snap_if.pool_present <= present;
    snap_if.element_word <= word;
    snap_if.capacity     <= cap;
    snap_if.free_slots   <= free;
    do @(posedge clk); while (!snap_if.ready);
  endtask

  // Waits until every outstanding result has come back and the block is idle.
  task automatic settle();
    snap_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called while idle.
  task automatic apply_settings(input bit en, input int unsigned res,
                                input int unsigned cs);
    logic [CFG_IDX_W-1:0]  slot [3];
    logic [CFG_DATA_W-1:0] value [3];
    slot  = '{REG_ENABLE, REG_RESERVE, REG_CAP_SETTING};
    value = '{CFG_DATA_W'(en), CFG_DATA_W'(res), CFG_DATA_W'(cs)};
    for (int k = 0; k < 3; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= slot[k];
      cfg_if.data  <= value[k];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly well-formed snapshots in the given band, plus noise and broken ones.
  task automatic random_snapshot(input free_band_t band, input int unsigned res);
    logic              present;
    logic [ELEM_W-1:0] word;
    logic [SLOT_W-1:0] cap;
    int unsigned       free;
    int unsigned       lo;
    int unsigned       pick;
    present = 1'b1;
    word    = {1'($urandom_range(1)), ELEM_SIZE_CODE};
    case (band)
      DEEP_SHORT: free = $urandom_range(res / 2, 0);
      SHORT:      free = $urandom_range(res, res / 2);
      NEAR:       free = res + $urandom_range(16);
      default:    free = $urandom_range(MAXCAP);
    endcase
    if (free > MAXCAP) free = MAXCAP;
    lo  = (free == 0) ? 1 : free;
    cap = ($urandom_range(3) == 0) ? SLOT_W'(lo) : SLOT_W'($urandom_range(MAXCAP, lo));
    pick = $urandom_range(99);
    if (pick < 8) begin
      present = 1'($urandom_range(1));
      word    = $urandom;
      cap     = SLOT_W'($urandom);
      free    = $urandom_range(16'hffff);
    end else if (pick < 16) begin
      case (flaw_t'($urandom_range(3)))
        DROP_PRESENT: present = 1'b0;
        BAD_WORD:     word = word ^ (32'd1 << $urandom_range(30));
        BAD_CAPACITY: cap = $urandom_range(1) ? '0 : SLOT_W'($urandom_range(16'hffff,
                                                                          MAXCAP + 1));
        default:      free = cap + $urandom_range(16'hffff - cap, 1);
      endcase
    end
    offer_snapshot(present, word, cap, SLOT_W'(free));
  endtask

  initial begin
    bit          en;
    int unsigned res;
    int unsigned cs;
    int unsigned streak;
    free_band_t  band;
    rst_n                <= 1'b0;
    steady               <= 1'b0;
    snap_if.valid        <= 1'b0;
    snap_if.pool_present <= 1'b0;
    snap_if.element_word <= '0;
    snap_if.capacity     <= '0;
    snap_if.free_slots   <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_ENABLE;
    cfg_if.data          <= '0;
    streak = 0;
    band   = ANY_FREE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Snapshot checks with the governor off after reset.
    offer_snapshot(1'b1, WORD_OK, 16'd4096, 16'd0);
    offer_snapshot(1'b0, WORD_OK, 16'd100, 16'd50);
    offer_snapshot(1'b1, 32'h0000_0a51, 16'd100, 16'd50);
    offer_snapshot(1'b1, 32'h8000_0a50, 16'd100, 16'd50);
    offer_snapshot(1'b1, WORD_OK, 16'd0, 16'd0);
    offer_snapshot(1'b1, WORD_OK, 16'd4097, 16'd10);
    offer_snapshot(1'b1, 32'hffff_ffff, 16'hffff, 16'hffff);
    offer_snapshot(1'b1, WORD_OK, 16'd10, 16'd11);
    offer_snapshot(1'b1, WORD_OK, 16'd1, 16'd1);

    // Cap already at the floor: a deep shortfall raises the second stage.
    settle();
    apply_settings(1'b1, 100, 0);
    offer_snapshot(1'b1, WORD_OK, 16'd200, 16'd10);
    offer_snapshot(1'b1, WORD_OK, 16'd200, 16'd60);

    // Turning the governor off clears the stage flag.
    settle();
    apply_settings(1'b0, 100, 0);
    offer_snapshot(1'b1, WORD_OK, 16'd200, 16'd60);

    // Full cap, then a cut by the deficit that leaves a held cap.
    settle();
    apply_settings(1'b1, 100, 1023);
    offer_snapshot(1'b1, WORD_OK, 16'd4096, 16'd10);

    // Setting lowered under the held cap: the cap is clamped.
    settle();
    apply_settings(1'b1, 100, 500);
    offer_snapshot(1'b1, WORD_OK, 16'd4096, 16'd100);

    // Largest reserve: the cut stops at the floor.
    settle();
    apply_settings(1'b1, 4096, 500);
    offer_snapshot(1'b1, WORD_OK, 16'd4096, 16'd0);
    offer_snapshot(1'b1, WORD_OK, 16'd4096, 16'd4096);

    // Zero reserve disables the governor.
    settle();
    apply_settings(1'b1, 0, 500);
    offer_snapshot(1'b1, WORD_OK, 16'd4096, 16'd5);

    // Smallest reserve and setting.
    settle();
    apply_settings(1'b1, 1, 1);
    offer_snapshot(1'b1, WORD_OK, 16'd1, 16'd0);

    // Random phases, each with its own settings and streaks of one free band.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        en = 1'b1; res = 4096; cs = 1023;
      end else if (phase == 1) begin
        en = 1'b1; res = 1; cs = 1;
      end else begin
        en = ($urandom_range(99) < 85);
        case ($urandom_range(4))
          0:       res = ($urandom_range(1) == 0) ? 0 : 4096;
          1:       res = $urandom_range(40, 1);
          2:       res = $urandom_range(400, 40);
          default: res = $urandom_range(4096, 400);
        endcase
        case ($urandom_range(4))
          0:       cs = 0;
          1:       cs = $urandom_range(19, 1);
          2:       cs = $urandom_range(200, 20);
          3:       cs = $urandom_range(1023, 200);
          default: cs = 1023;
        endcase
      end
      settle();
      steady <= (phase == 4) || (phase == 5);
      apply_settings(en, res, cs);
      for (int n = 0; n < 45; n++) begin
        if (streak == 0) begin
          band   = free_band_t'($urandom_range(3));
          streak = $urandom_range(30, 1);
        end
        streak--;
        random_snapshot(band, res);
      end
    end

    settle();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
rtl/pcg_pkg.sv
rtl/pcg_in_if.sv
rtl/pcg_out_if.sv
rtl/pcg_cfg_if.sv
rtl/pool_reserve_cap_governor_unit.sv
test/governor_checker.sv
test/testbench.sv
